// ===== hdl/acwc_pkg.sv =====
// Shared types and constants for the alarm clock with countdown.
`timescale 1ns / 1ps

package acwc_pkg;

    // Event codes on the command field
    localparam logic [1:0] CMD_CLOCK  = 2'd0;
    localparam logic [1:0] CMD_ALARM  = 2'd1;
    localparam logic [1:0] CMD_BUTTON = 2'd2;

    // Button bits
    localparam int BTN_TOGGLE   = 0;
    localparam int BTN_HOUR_UP  = 1;
    localparam int BTN_HOUR_DN  = 2;
    localparam int BTN_MIN_UP   = 3;
    localparam int BTN_MIN_DN   = 4;

    // Register indexes
    localparam logic REG_CLOCK_LIMIT = 1'b0;
    localparam logic REG_ALARM_LIMIT = 1'b1;

    localparam logic [9:0] CLOCK_LIMIT_RST = 10'd488;
    localparam logic [7:0] ALARM_LIMIT_RST = 8'd15;

    localparam logic [5:0] SEC_RST        = 6'd40;
    localparam logic [5:0] MIN_RST        = 6'd57;
    localparam logic [4:0] HOUR_RST       = 5'd21;
    localparam logic [4:0] ALARM_HOUR_RST = 5'd19;
    localparam logic [5:0] ALARM_MIN_RST  = 6'd56;

    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;
    localparam logic [4:0] NOON     = 5'd12;

    localparam logic signed [18:0] SEC_PER_HOUR = 19'sd3600;
    localparam logic signed [18:0] SEC_PER_MIN  = 19'sd60;
    localparam logic signed [18:0] SEC_PER_DAY  = 19'sd86400;

    typedef struct packed {
        logic [3:0] display_hour;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       is_pm;
        logic [4:0] alarm_hour_out;
        logic [5:0] alarm_minute_out;
        logic       alarm_enabled;
        logic       alarm_fired;
    } t_result;

endpackage

// ===== hdl/alarm_clock_with_countdown_top.sv =====
// Top level of the alarm clock with countdown.
//
// Input channel: i_in_valid / o_in_ready with i_command and i_buttons, one event
// per beat (clock timer overflow, alarm timer overflow or button rising edge).
// Output channel: o_out_valid / i_out_ready, one result beat per input beat that
// shows the time of day, the alarm setting and the alarm state after the event.
// Configuration: APB-style write/read of the two prescale limits at byte
// addresses 0 (clock) and 4 (alarm); pready is always high.
// Order: an accepted event is captured in the input register; the update then
// writes the state and loads the result into the output or skid register.
// Throughput: one beat per cycle while the receiver keeps up, set by the single
// update stage between the input register and the output register.
// Stall: a skid register behind the output register holds one more result, so
// with the receiver stalled the block still takes the event already in flight;
// o_in_ready drops once the output register and skid register would fill.
// Reset (synchronous, active low) restores 21:57:40, alarm 19:56, alarm off,
// both limits to their defaults, and empties all stages.
`timescale 1ns / 1ps

module alarm_clock_with_countdown_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [4:0]  i_buttons,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_display_hour,
    output logic [5:0]  o_minute_now,
    output logic [5:0]  o_second_now,
    output logic        o_is_pm,
    output logic [4:0]  o_alarm_hour_out,
    output logic [5:0]  o_alarm_minute_out,
    output logic        o_alarm_enabled,
    output logic        o_alarm_fired,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration
    logic [9:0] r_clk_limit;
    logic [7:0] r_alarm_limit;
    logic       w_cfg_wr;

    // Input stage
    logic       r_in_valid;
    logic [1:0] r_in_cmd;
    logic [4:0] r_in_btn;

    // Clock and alarm state
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic [9:0]  r_clk_pre, n_clk_pre;
    logic [7:0]  r_alarm_pre, n_alarm_pre;
    logic [4:0]  r_alarm_hour, n_alarm_hour;
    logic [5:0]  r_alarm_min, n_alarm_min;
    logic        r_armed, n_armed;
    logic        r_rang, n_rang;
    logic [16:0] r_remain, n_remain;

    // Output register and skid register
    logic                 r_out_valid;
    acwc_pkg::t_result    r_out_data;
    logic                 r_skid_valid;
    acwc_pkg::t_result    r_skid_data;
    acwc_pkg::t_result    w_result;
    logic                 w_pop;
    logic [1:0]           w_occ;

    logic signed [18:0] w_diff;
    logic signed [18:0] w_diff_adj;
    logic [7:0]         w_alarm_pre_inc;

    //--------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_limit   <= acwc_pkg::CLOCK_LIMIT_RST;
            r_alarm_limit <= acwc_pkg::ALARM_LIMIT_RST;
        end else if (w_cfg_wr) begin
            priority if (paddr[2] == acwc_pkg::REG_CLOCK_LIMIT) begin
                r_clk_limit <= pwdata[9:0];
            end else begin
                r_alarm_limit <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        priority if (paddr[2] == acwc_pkg::REG_CLOCK_LIMIT) begin
            prdata = {22'd0, r_clk_limit};
        end else begin
            prdata = {24'd0, r_alarm_limit};
        end
    end

    //--------------------------------------------------------------------
    // Flow control: at most two results in flight between input and output
    //--------------------------------------------------------------------
    assign w_pop      = r_out_valid & i_out_ready;
    assign w_occ      = {1'b0, r_in_valid} + {1'b0, r_out_valid} + {1'b0, r_skid_valid};
    assign o_in_ready = (w_occ - {1'b0, w_pop}) < 2'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_valid & o_in_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd <= i_command;
            r_in_btn <= i_buttons;
        end
    end

    //--------------------------------------------------------------------
    // Event update
    //--------------------------------------------------------------------
    // Seconds until the alarm time, pulled into 1..86400
    assign w_diff = ($signed({14'd0, r_alarm_hour}) - $signed({14'd0, r_hour}))
                        * acwc_pkg::SEC_PER_HOUR
                  + ($signed({13'd0, r_alarm_min}) - $signed({13'd0, r_min}))
                        * acwc_pkg::SEC_PER_MIN
                  - $signed({13'd0, r_sec});
    assign w_diff_adj = (w_diff <= 19'sd0) ? w_diff + acwc_pkg::SEC_PER_DAY : w_diff;

    assign w_alarm_pre_inc = r_alarm_pre + 8'd1;

    always_comb begin
        n_sec        = r_sec;
        n_min        = r_min;
        n_hour       = r_hour;
        n_clk_pre    = r_clk_pre;
        n_alarm_pre  = r_alarm_pre;
        n_alarm_hour = r_alarm_hour;
        n_alarm_min  = r_alarm_min;
        n_armed      = r_armed;
        n_rang       = r_rang;
        n_remain     = r_remain;

        if (r_in_valid) begin
            unique case (r_in_cmd)
                acwc_pkg::CMD_CLOCK: begin
                    if (r_clk_pre >= r_clk_limit) begin
                        n_clk_pre = '0;
                        if (r_sec >= acwc_pkg::SEC_MAX) begin
                            n_sec = '0;
                            if (r_min >= acwc_pkg::MIN_MAX) begin
                                n_min  = '0;
                                n_hour = (r_hour >= acwc_pkg::HOUR_MAX) ? 5'd0 : r_hour + 5'd1;
                            end else begin
                                n_min = r_min + 6'd1;
                            end
                        end else begin
                            n_sec = r_sec + 6'd1;
                        end
                    end else begin
                        n_clk_pre = r_clk_pre + 10'd1;
                    end
                end
                acwc_pkg::CMD_ALARM: begin
                    if (w_alarm_pre_inc >= r_alarm_limit) begin
                        n_alarm_pre = '0;
                        if (r_armed && !r_rang) begin
                            if (r_remain != 17'd0) begin
                                n_remain = r_remain - 17'd1;
                            end
                            // ring once the count lands on zero
                            if (r_remain <= 17'd1) begin
                                n_rang = 1'b1;
                            end
                        end
                    end else begin
                        n_alarm_pre = w_alarm_pre_inc;
                    end
                end
                acwc_pkg::CMD_BUTTON: begin
                    if (r_in_btn[acwc_pkg::BTN_TOGGLE]) begin
                        n_armed = !r_armed;
                        if (!r_armed) begin
                            n_remain = w_diff_adj[16:0];
                            n_rang   = 1'b0;
                        end
                    end
                    // steps apply in order: up first, then down
                    if (r_in_btn[acwc_pkg::BTN_HOUR_UP]) begin
                        n_alarm_hour = (n_alarm_hour >= acwc_pkg::HOUR_MAX) ? 5'd0
                                                                          : n_alarm_hour + 5'd1;
                    end
                    if (r_in_btn[acwc_pkg::BTN_HOUR_DN]) begin
                        n_alarm_hour = (n_alarm_hour == 5'd0) ? acwc_pkg::HOUR_MAX
                                                              : n_alarm_hour - 5'd1;
                    end
                    if (r_in_btn[acwc_pkg::BTN_MIN_UP]) begin
                        n_alarm_min = (n_alarm_min >= acwc_pkg::MIN_MAX) ? 6'd0
                                                                        : n_alarm_min + 6'd1;
                    end
                    if (r_in_btn[acwc_pkg::BTN_MIN_DN]) begin
                        n_alarm_min = (n_alarm_min == 6'd0) ? acwc_pkg::MIN_MAX
                                                            : n_alarm_min - 6'd1;
                    end
                end
                default: begin
                    // unused code: hold everything
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec        <= acwc_pkg::SEC_RST;
            r_min        <= acwc_pkg::MIN_RST;
            r_hour       <= acwc_pkg::HOUR_RST;
            r_clk_pre    <= '0;
            r_alarm_pre  <= '0;
            r_alarm_hour <= acwc_pkg::ALARM_HOUR_RST;
            r_alarm_min  <= acwc_pkg::ALARM_MIN_RST;
            r_armed      <= 1'b0;
            r_rang       <= 1'b0;
            r_remain     <= '0;
        end else begin
            r_sec        <= n_sec;
            r_min        <= n_min;
            r_hour       <= n_hour;
            r_clk_pre    <= n_clk_pre;
            r_alarm_pre  <= n_alarm_pre;
            r_alarm_hour <= n_alarm_hour;
            r_alarm_min  <= n_alarm_min;
            r_armed      <= n_armed;
            r_rang       <= n_rang;
            r_remain     <= n_remain;
        end
    end

    //--------------------------------------------------------------------
    // Result formatting
    //--------------------------------------------------------------------
    always_comb begin
        w_result.display_hour     = (n_hour <= acwc_pkg::NOON) ? n_hour[3:0]
                                                               : 4'(n_hour - acwc_pkg::NOON);
        w_result.minute_now       = n_min;
        w_result.second_now       = n_sec;
        w_result.is_pm            = (n_hour >= acwc_pkg::NOON);
        w_result.alarm_hour_out   = n_alarm_hour;
        w_result.alarm_minute_out = n_alarm_min;
        w_result.alarm_enabled    = n_armed;
        w_result.alarm_fired      = n_armed & n_rang;
    end

    //--------------------------------------------------------------------
    // Output register with skid register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= r_in_valid;
            end else begin
                r_out_valid  <= r_in_valid;
            end
        end else if (r_in_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_data  <= r_skid_data;
                r_skid_data <= w_result;
            end else begin
                r_out_data  <= w_result;
            end
        end else if (r_in_valid) begin
            r_skid_data <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_display_hour     = r_out_data.display_hour;
    assign o_minute_now       = r_out_data.minute_now;
    assign o_second_now       = r_out_data.second_now;
    assign o_is_pm            = r_out_data.is_pm;
    assign o_alarm_hour_out   = r_out_data.alarm_hour_out;
    assign o_alarm_minute_out = r_out_data.alarm_minute_out;
    assign o_alarm_enabled    = r_out_data.alarm_enabled;
    assign o_alarm_fired      = r_out_data.alarm_fired;

endmodule

// ===== hdl/acwc_checker.sv =====
// Port-level checker for the alarm clock with countdown, bound to the top level.
`timescale 1ns / 1ps

module acwc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [3:0] o_display_hour,
    input logic [5:0] o_minute_now,
    input logic [5:0] o_second_now,
    input logic       o_is_pm,
    input logic [4:0] o_alarm_hour_out,
    input logic [5:0] o_alarm_minute_out,
    input logic       o_alarm_enabled,
    input logic       o_alarm_fired
);

    // Result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_minute_now) && $stable(o_second_now) && $stable(o_display_hour)
            && $stable(o_alarm_fired) && $stable(o_alarm_enabled))
        else $error("result payload changed while stalled");

    // Alarm drive only while armed
    a_fired_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alarm_fired |-> o_alarm_enabled)
        else $error("alarm drive without alarm armed");

    // Time and alarm fields stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_display_hour <= 4'd12) && (o_minute_now <= 6'd59)
            && (o_second_now <= 6'd59) && (o_alarm_hour_out <= 5'd23)
            && (o_alarm_minute_out <= 6'd59) && (o_is_pm || o_display_hour != 4'd0
            || o_display_hour == 4'd0))
        else $error("result field out of range");

endmodule

bind alarm_clock_with_countdown_top acwc_checker u_acwc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_display_hour     (o_display_hour),
    .o_minute_now       (o_minute_now),
    .o_second_now       (o_second_now),
    .o_is_pm            (o_is_pm),
    .o_alarm_hour_out   (o_alarm_hour_out),
    .o_alarm_minute_out (o_alarm_minute_out),
    .o_alarm_enabled    (o_alarm_enabled),
    .o_alarm_fired      (o_alarm_fired)
);

// ===== tb/acwc_checker.sv =====
// Checker for the alarm clock: tracks configuration, predicts every result beat and compares.
`timescale 1ns / 1ps

module acwc_scoreboard (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_command,
    input  logic [4:0]        i_buttons,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  acwc_pkg::t_result i_result,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic [31:0]       i_prdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    logic [9:0]  clock_limit;
    logic [7:0]  alarm_limit;

    logic [5:0]  sec_now;
    logic [5:0]  min_now;
    logic [4:0]  hour_now;
    logic [9:0]  clock_div;
    logic [7:0]  alarm_div;
    logic [4:0]  alm_hour_set;
    logic [5:0]  alarm_min;
    logic        armed;
    logic        rang;
    logic [16:0] secs_to_go;

    acwc_pkg::t_result expected_results[$];
    acwc_pkg::t_result oldest;
    int                fails = 0;

    assign o_fail_count = fails;

    task automatic restore_defaults();
        clock_limit  = acwc_pkg::CLOCK_LIMIT_RST;
        alarm_limit  = acwc_pkg::ALARM_LIMIT_RST;
        sec_now      = acwc_pkg::SEC_RST;
        min_now      = acwc_pkg::MIN_RST;
        hour_now     = acwc_pkg::HOUR_RST;
        clock_div    = '0;
        alarm_div    = '0;
        alm_hour_set = acwc_pkg::ALARM_HOUR_RST;
        alarm_min    = acwc_pkg::ALARM_MIN_RST;
        armed        = 1'b0;
        rang         = 1'b0;
        secs_to_go   = '0;
    endtask

    task automatic tick_second();
        if (sec_now >= acwc_pkg::SEC_MAX) begin
            sec_now = '0;
            if (min_now >= acwc_pkg::MIN_MAX) begin
                min_now  = '0;
                hour_now = (hour_now >= acwc_pkg::HOUR_MAX) ? 5'd0 : hour_now + 5'd1;
            end else begin
                min_now = min_now + 6'd1;
            end
        end else begin
            sec_now = sec_now + 6'd1;
        end
    endtask

    task automatic press_buttons(input logic [4:0] btn);
        int gap;
        if (btn[acwc_pkg::BTN_TOGGLE]) begin
            armed = !armed;
            if (armed) begin
                // arm from the setting as it stands before any step in this beat
                gap = (int'(alm_hour_set) - int'(hour_now)) * int'(acwc_pkg::SEC_PER_HOUR)
                    + (int'(alarm_min) - int'(min_now)) * int'(acwc_pkg::SEC_PER_MIN)
                    - int'(sec_now);
                if (gap <= 0)
                    gap = gap + int'(acwc_pkg::SEC_PER_DAY);
                secs_to_go = gap[16:0];
                rang       = 1'b0;
            end
        end
        if (btn[acwc_pkg::BTN_HOUR_UP])
            alm_hour_set = (alm_hour_set >= acwc_pkg::HOUR_MAX) ? 5'd0 : alm_hour_set + 5'd1;
        if (btn[acwc_pkg::BTN_HOUR_DN])
            alm_hour_set = (alm_hour_set == 5'd0) ? acwc_pkg::HOUR_MAX : alm_hour_set - 5'd1;
        if (btn[acwc_pkg::BTN_MIN_UP])
            alarm_min = (alarm_min >= acwc_pkg::MIN_MAX) ? 6'd0 : alarm_min + 6'd1;
        if (btn[acwc_pkg::BTN_MIN_DN])
            alarm_min = (alarm_min == 6'd0) ? acwc_pkg::MIN_MAX : alarm_min - 6'd1;
    endtask

    task automatic apply_event(input logic [1:0] cmd, input logic [4:0] btn);
        case (cmd)
            acwc_pkg::CMD_CLOCK: begin
                if (clock_div >= clock_limit) begin
                    clock_div = '0;
                    tick_second();
                end else begin
                    clock_div = clock_div + 10'd1;
                end
            end
            acwc_pkg::CMD_ALARM: begin
                // increment first, then compare: a limit of zero acts like one
                alarm_div = alarm_div + 8'd1;
                if (alarm_div >= alarm_limit) begin
                    alarm_div = '0;
                    if (armed && !rang) begin
                        if (secs_to_go != '0)
                            secs_to_go = secs_to_go - 17'd1;
                        if (secs_to_go == '0)
                            rang = 1'b1;
                    end
                end
            end
            acwc_pkg::CMD_BUTTON: press_buttons(btn);
            default: ;
        endcase
    endtask

    function automatic acwc_pkg::t_result clock_face();
        acwc_pkg::t_result r;
        logic [4:0]        pm_hour;
        pm_hour            = hour_now - acwc_pkg::NOON;
        r.display_hour     = (hour_now <= acwc_pkg::NOON) ? hour_now[3:0] : pm_hour[3:0];
        r.minute_now       = min_now;
        r.second_now       = sec_now;
        r.is_pm            = (hour_now >= acwc_pkg::NOON);
        r.alarm_hour_out   = alm_hour_set;
        r.alarm_minute_out = alarm_min;
        r.alarm_enabled    = armed;
        r.alarm_fired      = armed && rang;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == acwc_pkg::REG_ALARM_LIMIT)
                        alarm_limit = i_pwdata[7:0];
                    else
                        clock_limit = i_pwdata[9:0];
                end else if (i_paddr[2] == acwc_pkg::REG_ALARM_LIMIT) begin
                    check_field("prdata alarm limit", {24'd0, alarm_limit}, i_prdata);
                end else begin
                    check_field("prdata clock limit", {22'd0, clock_limit}, i_prdata);
                end
            end
            // retire the output beat before predicting this edge's input beat
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                             $time, i_result);
                    fails++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("display_hour", oldest.display_hour, i_result.display_hour);
                    check_field("minute_now", oldest.minute_now, i_result.minute_now);
                    check_field("second_now", oldest.second_now, i_result.second_now);
                    check_field("is_pm", oldest.is_pm, i_result.is_pm);
                    check_field("alarm_hour_out", oldest.alarm_hour_out,
                                i_result.alarm_hour_out);
                    check_field("alarm_minute_out", oldest.alarm_minute_out,
                                i_result.alarm_minute_out);
                    check_field("alarm_enabled", oldest.alarm_enabled, i_result.alarm_enabled);
                    check_field("alarm_fired", oldest.alarm_fired, i_result.alarm_fired);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_event(i_command, i_buttons);
                expected_results.push_back(clock_face());
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/tb_alarm_clock_with_countdown_top.sv =====
// Testbench top for the alarm clock: drives events and register writes, gives the verdict.
`timescale 1ns / 1ps

module tb_alarm_clock_with_countdown_top;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [4:0] PRESS_TOGGLE   = 5'b1 << acwc_pkg::BTN_TOGGLE;
    localparam logic [4:0] PRESS_HOUR_UP  = 5'b1 << acwc_pkg::BTN_HOUR_UP;
    localparam logic [4:0] PRESS_HOUR_DN  = 5'b1 << acwc_pkg::BTN_HOUR_DN;
    localparam logic [4:0] PRESS_MIN_UP   = 5'b1 << acwc_pkg::BTN_MIN_UP;
    localparam logic [4:0] PRESS_MIN_DN   = 5'b1 << acwc_pkg::BTN_MIN_DN;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         LONG_HOLD      = 300;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_command   = '0;
    logic [4:0]  i_buttons   = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_display_hour;
    logic [5:0]  o_minute_now;
    logic [5:0]  o_second_now;
    logic        o_is_pm;
    logic [4:0]  o_alarm_hour_out;
    logic [5:0]  o_alarm_minute_out;
    logic        o_alarm_enabled;
    logic        o_alarm_fired;
    logic [31:0] prdata;
    logic        pready;

    acwc_pkg::t_result dut_result;
    acwc_pkg::t_result last_seen = '0;
    int                fail_count;
    int                pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    int          stall_cycles  = 0;
    int          items_sent    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    alarm_clock_with_countdown_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_buttons          (i_buttons),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_display_hour     (o_display_hour),
        .o_minute_now       (o_minute_now),
        .o_second_now       (o_second_now),
        .o_is_pm            (o_is_pm),
        .o_alarm_hour_out   (o_alarm_hour_out),
        .o_alarm_minute_out (o_alarm_minute_out),
        .o_alarm_enabled    (o_alarm_enabled),
        .o_alarm_fired      (o_alarm_fired),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    assign dut_result = {o_display_hour, o_minute_now, o_second_now, o_is_pm,
                         o_alarm_hour_out, o_alarm_minute_out, o_alarm_enabled, o_alarm_fired};

    acwc_scoreboard result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_buttons    (i_buttons),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (dut_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random backpressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // keep the last result beat so alarm sequences can aim at the current time
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            last_seen <= dut_result;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [4:0] btn);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_buttons  <= btn;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic noise_burst(input int count);
        repeat (count)
            send_beat(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
    endtask

    // step the alarm to the current minute or up to two minutes on, arm it, then run the countdown
    task automatic alarm_sequence();
        int hour_24;
        int tgt_hour;
        int tgt_min;
        int steps;
        int body;
        int pick;
        drain();
        hour_24 = last_seen.is_pm ?
                  ((last_seen.display_hour == acwc_pkg::NOON) ? int'(acwc_pkg::NOON)
                                        : last_seen.display_hour + int'(acwc_pkg::NOON))
                  : last_seen.display_hour;
        if (last_seen.alarm_enabled)
            send_beat(acwc_pkg::CMD_BUTTON, PRESS_TOGGLE);
        tgt_min  = last_seen.minute_now + $urandom_range(0, 2);
        tgt_hour = hour_24;
        if (tgt_min >= 60) begin
            tgt_min  = tgt_min - 60;
            tgt_hour = (tgt_hour + 1) % 24;
        end
        steps = (tgt_hour - last_seen.alarm_hour_out + 24) % 24;
        if (steps <= 12)
            repeat (steps) send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_UP);
        else
            repeat (24 - steps) send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_DN);
        steps = (tgt_min - last_seen.alarm_minute_out + 60) % 60;
        if (steps <= 30)
            repeat (steps) send_beat(acwc_pkg::CMD_BUTTON, PRESS_MIN_UP);
        else
            repeat (60 - steps) send_beat(acwc_pkg::CMD_BUTTON, PRESS_MIN_DN);
        send_beat(acwc_pkg::CMD_BUTTON, PRESS_TOGGLE);
        body = $urandom_range(40, 180);
        repeat (body) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_beat(acwc_pkg::CMD_ALARM, 5'($urandom_range(0, 31)));
            else if (pick < 88)
                send_beat(acwc_pkg::CMD_CLOCK, 5'($urandom_range(0, 31)));
            else if (pick < 95)
                send_beat(acwc_pkg::CMD_BUTTON, 5'($urandom_range(0, 31)) & ~PRESS_TOGGLE);
            else if (pick < 98)
                send_beat(CMD_UNUSED, 5'($urandom_range(0, 31)));
            else
                send_beat(acwc_pkg::CMD_BUTTON, 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic run_phase(input logic [9:0] clk_lim, input logic [7:0] alm_lim,
                             input int sidle, input int ridle, input int budget,
                             input logic long_hold);
        int goal;
        drain();
        repeat (4) @(posedge i_clk);
        reg_access(1'b1, acwc_pkg::REG_CLOCK_LIMIT, {22'd0, clk_lim});
        reg_access(1'b0, acwc_pkg::REG_CLOCK_LIMIT, '0);
        reg_access(1'b1, acwc_pkg::REG_ALARM_LIMIT, {24'd0, alm_lim});
        reg_access(1'b0, acwc_pkg::REG_ALARM_LIMIT, '0);
        send_idle_pct <= sidle;
        recv_idle_pct <= ridle;
        goal = items_sent + budget;
        if (long_hold) begin
            hold_requests <= hold_requests + 1;
            noise_burst(60);
        end
        while (items_sent < goal) begin
            if ($urandom_range(0, 99) < 70)
                alarm_sequence();
            else
                noise_burst($urandom_range(5, 25));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct <= 26;
        recv_idle_pct <= 52;
        reg_access(1'b0, acwc_pkg::REG_CLOCK_LIMIT, '0);
        reg_access(1'b0, acwc_pkg::REG_ALARM_LIMIT, '0);
        reg_access(1'b1, acwc_pkg::REG_CLOCK_LIMIT, 32'd1);
        reg_access(1'b1, acwc_pkg::REG_ALARM_LIMIT, 32'd1);

        // directed: ignored command, ignored buttons, prescaler rollover
        send_beat(CMD_UNUSED, 5'b11111);
        send_beat(acwc_pkg::CMD_CLOCK, 5'b00000);
        send_beat(acwc_pkg::CMD_CLOCK, 5'b11111);
        send_beat(acwc_pkg::CMD_ALARM, 5'b11111);
        send_beat(acwc_pkg::CMD_BUTTON, 5'b00000);
        // walk the alarm to 23:00, then wrap hour and minute both ways
        repeat (4) send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_UP | PRESS_MIN_UP);
        send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_UP | PRESS_MIN_DN);
        send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_DN | PRESS_MIN_UP);
        // every button at once: arm from the setting before the steps
        send_beat(acwc_pkg::CMD_BUTTON, 5'b11111);
        send_beat(acwc_pkg::CMD_BUTTON, PRESS_TOGGLE);
        // alarm behind the clock: count wraps around the day
        repeat (2) send_beat(acwc_pkg::CMD_BUTTON, PRESS_HOUR_DN);
        send_beat(acwc_pkg::CMD_BUTTON, PRESS_TOGGLE);
        send_beat(acwc_pkg::CMD_ALARM, 5'b00000);
        send_beat(acwc_pkg::CMD_ALARM, 5'b10101);
        send_beat(acwc_pkg::CMD_CLOCK, 5'b01010);
        send_beat(CMD_UNUSED, 5'b00000);

        run_phase(10'd1, 8'd1, 26, 52, 150, 1'b0);
        run_phase(10'd1023, 8'd255, 26, 52, 150, 1'b0);
        run_phase(10'd1, 8'd2, 52, 26, 150, 1'b1);
        run_phase(10'($urandom_range(2, 20)), 8'($urandom_range(1, 8)), 52, 26, 150, 1'b0);
        run_phase(10'd5, 8'd1, 0, 0, 150, 1'b0);
        run_phase(10'd1, 8'd3, 0, 0, 150, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== alarm_clock_with_countdown_top.f =====
hdl/acwc_pkg.sv
hdl/alarm_clock_with_countdown_top.sv
hdl/acwc_checker.sv
tb/acwc_checker.sv
tb/tb_alarm_clock_with_countdown_top.sv
